@@ hdl/hfrc_pkg.sv @@
// Shared constants, command codes and controller-to-datapath command type for the helix fit.
package hfrc_pkg;

    // Default number of hit slots per track
    localparam int DEF_MAX_HITS = 16;

    // Fixed-point shifts of the helix terms
    localparam int CURV_SHIFT   = 16;
    localparam int TAN_SHIFT    = 16;
    localparam int IMPACT_SHIFT = 8;

    // Residual range, common to phi and z
    localparam int RES_MAX = 131071;
    localparam int RES_MIN = -131072;

    // Field and product widths
    localparam int PAR_W   = 18;
    localparam int RAD_W   = 16;
    localparam int ZPOS_W  = 16;
    localparam int MUL_W   = 2 * PAR_W;
    localparam int CHISQ_W = 40;
    localparam int IDX_W   = 4;

    // Divider: magnitude of the impact term scaled up, two quotient bits per cycle
    localparam int DIV_BITS  = PAR_W + IMPACT_SHIFT;
    localparam int DIV_STEPS = DIV_BITS / 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CURVATURE   = 3'd0;
    localparam logic [2:0] CFG_PHI_OFFSET  = 3'd1;
    localparam logic [2:0] CFG_IMPACT_TERM = 3'd2;
    localparam logic [2:0] CFG_Z_OFFSET    = 3'd3;
    localparam logic [2:0] CFG_TAN_LAMBDA  = 3'd4;

    // Shared multiplier operand selection
    localparam logic [1:0] MUL_R_CURV = 2'd0;
    localparam logic [1:0] MUL_R_TAN  = 2'd1;
    localparam logic [1:0] MUL_PHI_SQ = 2'd2;
    localparam logic [1:0] MUL_Z_SQ   = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;      // capture hit, start divider
        logic       mul_en;    // register a product
        logic [1:0] mul_sel;   // operand pair for the multiplier
        logic       cterm_en;  // keep the curvature term
        logic       div_step;  // advance the divider
        logic       res_en;    // register both residuals
        logic       sqp_en;    // keep the phi square
        logic       acc_en;    // update track totals and load the result
    } cmd_t;

endpackage

@@ hdl/hfrc_ctrl.sv @@
// Sequencing state machine for the helix residual and chi-square unit.
module hfrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output hfrc_pkg::cmd_t    cmd
);
    import hfrc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULC  = 3'd1;
    localparam logic [2:0] S_MULT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RES   = 3'd4;
    localparam logic [2:0] S_SQP   = 3'd5;
    localparam logic [2:0] S_SQZ   = 3'd6;
    localparam logic [2:0] S_ACC   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Step through the work of one hit
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULC;
                end
            end
            S_MULC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_R_CURV;
                state_next  = S_MULT;
            end
            S_MULT:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_R_TAN;
                cmd.cterm_en = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RES:
            begin
                cmd.res_en = 1'b1;
                state_next = S_SQP;
            end
            S_SQP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PHI_SQ;
                state_next  = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Z_SQ;
                cmd.sqp_en  = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.acc_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set when the result register is loaded, drop after the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.acc_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/hfrc_dp.sv @@
// Datapath: track registers, shared multiplier, radix-4 divider and track totals.
module hfrc_dp #(
    parameter int MAX_HITS = hfrc_pkg::DEF_MAX_HITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hfrc_pkg::cmd_t       cmd,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [17:0]          cfg_data,
    input  logic [15:0]          hit_radius,
    input  logic signed [15:0]   hit_z,
    input  logic signed [17:0]   hit_phi,
    input  logic                 last_hit,
    output logic signed [17:0]   phi_residual,
    output logic signed [17:0]   z_residual,
    output logic [39:0]          chi_square,
    output logic [17:0]          largest_residual,
    output logic [3:0]           largest_hit_index,
    output logic                 track_done
);
    import hfrc_pkg::*;

    localparam int HC_W  = $clog2(MAX_HITS);
    localparam int SUM_W = CHISQ_W + 1;
    localparam int PD_W  = 30;
    localparam int ZD_W  = 22;
    localparam int CT_W  = MUL_W - CURV_SHIFT;
    localparam int TT_W  = MUL_W - TAN_SHIFT;

    localparam logic signed [PD_W-1:0]  PHI_HI = PD_W'(RES_MAX);
    localparam logic signed [PD_W-1:0]  PHI_LO = PD_W'(RES_MIN);
    localparam logic signed [ZD_W-1:0]  Z_HI   = ZD_W'(RES_MAX);
    localparam logic signed [ZD_W-1:0]  Z_LO   = ZD_W'(RES_MIN);
    localparam logic signed [PAR_W-1:0] RES_HI = PAR_W'(RES_MAX);
    localparam logic signed [PAR_W-1:0] RES_LO = PAR_W'(RES_MIN);

    // Track parameter registers
    logic signed [PAR_W-1:0]  curv_reg, phi0_reg, d1_reg, tl_reg;
    logic signed [ZPOS_W-1:0] z0_reg;

    // Hit being worked on
    logic [RAD_W-1:0]         r_reg;
    logic signed [ZPOS_W-1:0] z_reg;
    logic signed [PAR_W-1:0]  phi_reg;
    logic                     last_reg;

    // Working registers
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [CT_W-1:0]   cterm_reg;
    logic [DIV_BITS-1:0]      q_reg;
    logic [RAD_W-1:0]         rem_reg;
    logic signed [PAR_W-1:0]  rphi_reg, rz_reg;
    logic [MUL_W-1:0]         sqp_reg;

    // Track totals
    logic [CHISQ_W-1:0]       chisq_reg;
    logic [PAR_W-1:0]         max_reg;
    logic [HC_W-1:0]          idx_reg;
    logic [HC_W-1:0]          hc_reg;
    logic                     any_reg;

    // Result register
    logic signed [PAR_W-1:0]  phi_res_reg, z_res_reg;
    logic [CHISQ_W-1:0]       chi_reg;
    logic [PAR_W-1:0]         big_reg;
    logic [IDX_W-1:0]         big_idx_reg;
    logic                     done_reg;

    logic [PAR_W-1:0]         d1_mag;
    logic signed [PAR_W-1:0]  mul_a, mul_b;
    logic [RAD_W:0]           rem_a, rem_a2, rem_b, rem_b2, dvs;
    logic                     qa, qb;
    logic signed [DIV_BITS:0] quot_s;
    logic signed [TT_W-1:0]   tterm;
    logic signed [PD_W-1:0]   pred, pdiff;
    logic signed [ZD_W-1:0]   zdiff;
    logic signed [PAR_W-1:0]  rphi_next, rz_next;
    logic [PAR_W-1:0]         abs_p, abs_z, m1, m2;
    logic [HC_W-1:0]          i1, i2;
    logic [HC_W+IDX_W-1:0]    i2_ext;
    logic                     take_p, take_z;
    logic [SUM_W-1:0]         sum;
    logic [CHISQ_W-1:0]       chisq_new;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curv_reg <= '0;
            phi0_reg <= '0;
            d1_reg   <= '0;
            z0_reg   <= '0;
            tl_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CURVATURE:   curv_reg <= cfg_data;
                CFG_PHI_OFFSET:  phi0_reg <= cfg_data;
                CFG_IMPACT_TERM: d1_reg   <= cfg_data;
                CFG_Z_OFFSET:    z0_reg   <= cfg_data[ZPOS_W-1:0];
                CFG_TAN_LAMBDA:  tl_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign d1_mag = d1_reg[PAR_W-1] ? PAR_W'(-d1_reg) : d1_reg;

    // Shared multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_R_CURV:
            begin
                mul_a = $signed({2'b00, r_reg});
                mul_b = curv_reg;
            end
            MUL_R_TAN:
            begin
                mul_a = $signed({2'b00, r_reg});
                mul_b = tl_reg;
            end
            MUL_PHI_SQ:
            begin
                mul_a = rphi_reg;
                mul_b = rphi_reg;
            end
            MUL_Z_SQ:
            begin
                mul_a = rz_reg;
                mul_b = rz_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Two restoring division steps per cycle
    always_comb
    begin
        dvs    = {1'b0, r_reg};
        rem_a  = {rem_reg, q_reg[DIV_BITS-1]};
        qa     = (rem_a >= dvs);
        rem_a2 = qa ? (rem_a - dvs) : rem_a;
        rem_b  = {rem_a2[RAD_W-1:0], q_reg[DIV_BITS-2]};
        qb     = (rem_b >= dvs);
        rem_b2 = qb ? (rem_b - dvs) : rem_b;
    end

    // Residuals with saturation; zero radius forces the phi residual to a rail
    always_comb
    begin
        quot_s = d1_reg[PAR_W-1] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        tterm  = prod_reg[MUL_W-1:TAN_SHIFT];
        pred   = PD_W'(phi0_reg) + PD_W'(cterm_reg) + PD_W'(quot_s);
        pdiff  = PD_W'(phi_reg) - pred;
        zdiff  = ZD_W'(z_reg) - ZD_W'(z0_reg) - ZD_W'(tterm);

        if (r_reg == '0)
        begin
            rphi_next = d1_reg[PAR_W-1] ? RES_HI : RES_LO;
        end
        else if (pdiff > PHI_HI)
        begin
            rphi_next = RES_HI;
        end
        else if (pdiff < PHI_LO)
        begin
            rphi_next = RES_LO;
        end
        else
        begin
            rphi_next = pdiff[PAR_W-1:0];
        end

        if (zdiff > Z_HI)
        begin
            rz_next = RES_HI;
        end
        else if (zdiff < Z_LO)
        begin
            rz_next = RES_LO;
        end
        else
        begin
            rz_next = zdiff[PAR_W-1:0];
        end
    end

    // Largest residual, phi first; strictly larger takes over
    always_comb
    begin
        abs_p  = rphi_reg[PAR_W-1] ? PAR_W'(-rphi_reg) : rphi_reg;
        abs_z  = rz_reg[PAR_W-1] ? PAR_W'(-rz_reg) : rz_reg;
        take_p = !any_reg || (abs_p > max_reg);
        m1     = take_p ? abs_p : max_reg;
        i1     = take_p ? hc_reg : idx_reg;
        take_z = (abs_z > m1);
        m2     = take_z ? abs_z : m1;
        i2     = take_z ? hc_reg : i1;
        i2_ext = {{IDX_W{1'b0}}, i2};
    end

    // Saturating chi-square sum; the z square still sits in the product register
    always_comb
    begin
        sum       = {1'b0, chisq_reg} + SUM_W'(sqp_reg) + SUM_W'($unsigned(prod_reg));
        chisq_new = sum[CHISQ_W] ? {CHISQ_W{1'b1}} : sum[CHISQ_W-1:0];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg    <= hit_radius;
            z_reg    <= hit_z;
            phi_reg  <= hit_phi;
            last_reg <= last_hit;
            q_reg    <= {d1_mag, {IMPACT_SHIFT{1'b0}}};
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[DIV_BITS-3:0], qa, qb};
            rem_reg <= rem_b2[RAD_W-1:0];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.cterm_en)
        begin
            cterm_reg <= prod_reg[MUL_W-1:CURV_SHIFT];
        end
        if (cmd.res_en)
        begin
            rphi_reg <= rphi_next;
            rz_reg   <= rz_next;
        end
        if (cmd.sqp_en)
        begin
            sqp_reg <= $unsigned(prod_reg);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            phi_res_reg <= rphi_reg;
            z_res_reg   <= rz_reg;
            chi_reg     <= chisq_new;
            big_reg     <= m2;
            big_idx_reg <= i2_ext[IDX_W-1:0];
            done_reg    <= last_reg;
        end
    end

    // Track totals; clear after the last hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chisq_reg <= '0;
            max_reg   <= '0;
            idx_reg   <= '0;
            hc_reg    <= '0;
            any_reg   <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (last_reg)
            begin
                chisq_reg <= '0;
                max_reg   <= '0;
                idx_reg   <= '0;
                hc_reg    <= '0;
                any_reg   <= 1'b0;
            end
            else
            begin
                chisq_reg <= chisq_new;
                max_reg   <= m2;
                idx_reg   <= i2;
                any_reg   <= 1'b1;
                if (hc_reg < HC_W'(MAX_HITS - 1))
                begin
                    hc_reg <= hc_reg + 1'b1;
                end
            end
        end
    end

    assign phi_residual      = phi_res_reg;
    assign z_residual        = z_res_reg;
    assign chi_square        = chi_reg;
    assign largest_residual  = big_reg;
    assign largest_hit_index = big_idx_reg;
    assign track_done        = done_reg;

endmodule

@@ hdl/helix_fit_residual_chisq.sv @@
// Helix fit residuals: phi and z residuals per hit, running chi-square and largest residual.
// Per hit: capture, the two helix products, the divider, the residuals, the two squares, the totals.
// The divider for the impact term (two quotient bits a cycle) and the one shared
// 18x18 multiplier, used four times per hit, work in turn; one hit is in flight.
// A new hit is taken while the previous result still waits on out_stall.
// Reset (rst_n low, asynchronous) clears the track registers, totals and valid flags.
module helix_fit_residual_chisq #(
    parameter int MAX_HITS = hfrc_pkg::DEF_MAX_HITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         hit_radius,
    input  logic signed [15:0]  hit_z,
    input  logic signed [17:0]  hit_phi,
    input  logic                last_hit,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [17:0]  phi_residual,
    output logic signed [17:0]  z_residual,
    output logic [39:0]         chi_square,
    output logic [17:0]         largest_residual,
    output logic [3:0]          largest_hit_index,
    output logic                track_done,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [17:0]         cfg_data
);
    import hfrc_pkg::*;

    cmd_t cmd;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    hfrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    hfrc_dp #(
        .MAX_HITS (MAX_HITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .hit_radius        (hit_radius),
        .hit_z             (hit_z),
        .hit_phi           (hit_phi),
        .last_hit          (last_hit),
        .phi_residual      (phi_residual),
        .z_residual        (z_residual),
        .chi_square        (chi_square),
        .largest_residual  (largest_residual),
        .largest_hit_index (largest_hit_index),
        .track_done        (track_done)
    );

    // One hit in flight: stall straight after an input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a hit is in flight");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en |-> (!out_valid || !out_stall))
        else $error("result register loaded while stalled");

    // Datapath phases never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_en, cmd.div_step, cmd.res_en, cmd.acc_en}))
        else $error("overlapping datapath commands");

endmodule
